>>> hw/rtl/sbm_pkg.sv
`default_nettype none

package sbm_pkg;

  // Bus operations carried by a request item
  typedef enum logic [1:0] {
    OP_CPU_READ  = 2'd0,
    OP_CPU_WRITE = 2'd1,
    OP_PPU_READ  = 2'd2
  } op_t;

  // Region codes of a result item
  typedef enum logic [1:0] {
    REGION_NONE = 2'd0,
    REGION_WRAM = 2'd1,
    REGION_PRG  = 2'd2,
    REGION_CHR  = 2'd3
  } region_t;

  // Serial register targets, from address bits 14..13
  typedef enum logic [1:0] {
    TGT_CONTROL = 2'd0,
    TGT_CHR0    = 2'd1,
    TGT_CHR1    = 2'd2,
    TGT_PRG     = 2'd3
  } target_t;

  // PRG modes, control bits 3..2
  localparam logic [1:0] PRG_MODE_32K_A     = 2'd0;
  localparam logic [1:0] PRG_MODE_32K_B     = 2'd1;
  localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

  localparam logic [4:0] CTRL_RESET     = 5'h1C;
  localparam logic [4:0] CTRL_FORCE_16K = 5'h0C;
  // Bank count is kept mod 16; 16 banks reads as zero
  localparam logic [3:0] PRG_COUNT_RESET = 4'd0;
  localparam logic [2:0] SHIFT_LAST      = 3'd4;

  localparam int unsigned CTRL_PRG_16K_BIT = 3;
  localparam int unsigned CTRL_CHR_4K_BIT  = 4;

  // Mapper register state seen by the translation logic
  typedef struct packed {
    logic [4:0] control;
    logic [4:0] chr_low;
    logic [4:0] chr_high;
    logic [3:0] chr_whole_half;  // 8K CHR bank, in units of 8K
    logic [3:0] prg_low;
    logic [3:0] prg_high;
    logic [2:0] prg_whole;
    logic [2:0] shift_count;
  } bank_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/sbm_req_if.sv
`default_nettype none

interface sbm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, output operation, output address, output write_data,
                  input ready);
  modport sink (input valid, input operation, input address, input write_data,
                output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sbm_rsp_if.sv
`default_nettype none

interface sbm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  region;
  logic [17:0] mapped_address;
  logic [1:0]  mirroring;

  modport source (output valid, output region, output mapped_address, output mirroring,
                  input ready);
  modport sink (input valid, input region, input mapped_address, input mirroring,
                output ready);
endinterface

`default_nettype wire

>>> hw/rtl/serial_bank_mapper_core.sv
// Cartridge bank mapper, serial-load kind.
// req carries CPU reads, CPU writes and PPU pattern reads (operation,
// address, write_data); rsp returns one item per request: region, offset
// into that region after banking, and the mirroring mode.
// Handshake on both channels is valid/ready; an item moves on an edge
// where both are high.
// A request is held in an input register and translated there; the edge
// that moves it out commits it to the bank registers and lands it in the
// result register, so its result is valid from that edge on. A stall on
// rsp can hold it in the input register.
// Throughput is one item per cycle while rsp does not stall; the input
// register takes a new item while a finished result waits in the result
// register. When rsp stalls, both registers fill and req.ready drops.
// cfg_write_en / cfg_write_data set the PRG bank count and load the last
// bank into prg_high; write it only while no item is in flight.
// Reset (rst, synchronous) empties both registers and restores the bank
// registers: control 0x1C, 16 banks, last bank 15, all others zero.
`default_nettype none

module serial_bank_mapper_core (
  input  wire logic       clk,
  input  wire logic       rst,
  sbm_req_if.sink         req,
  sbm_rsp_if.source       rsp,
  input  wire logic       cfg_write_en,
  input  wire logic [4:0] cfg_write_data
);

  logic        in_valid;
  logic [1:0]  in_op;
  logic [15:0] in_addr;
  logic [7:0]  in_data;
  logic        out_valid;
  logic        advance;
  logic        step;

  sbm_pkg::bank_state_t state;
  logic [4:0]           control_next;
  sbm_pkg::region_t     region_c;
  logic [17:0]          mapped_c;
  logic [3:0]           prg_bank;
  logic [4:0]           chr_bank;

  assign advance   = !out_valid || rsp.ready;
  assign step      = in_valid && advance;
  assign req.ready = !in_valid || advance;
  assign rsp.valid = out_valid;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_op   <= req.operation;
      in_addr <= req.address;
      in_data <= req.write_data;
    end
  end

  sbm_serial u_serial (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .operation      (in_op),
    .addr_top       (in_addr[15:13]),
    .write_data     (in_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .state          (state),
    .control_next   (control_next)
  );

  // Address translation from the current bank state
  always_comb begin
    region_c = sbm_pkg::REGION_NONE;
    mapped_c = '0;
    prg_bank = in_addr[14] ? state.prg_high : state.prg_low;
    chr_bank = in_addr[12] ? state.chr_high : state.chr_low;
    case (in_op)
      sbm_pkg::OP_CPU_READ, sbm_pkg::OP_CPU_WRITE: begin
        if (in_addr[15:13] == 3'b011) begin
          region_c = sbm_pkg::REGION_WRAM;
          mapped_c = {5'd0, in_addr[12:0]};
        end else if (in_addr[15] && (in_op == sbm_pkg::OP_CPU_READ)) begin
          region_c = sbm_pkg::REGION_PRG;
          if (state.control[sbm_pkg::CTRL_PRG_16K_BIT]) begin
            mapped_c = {prg_bank, in_addr[13:0]};
          end else begin
            mapped_c = {state.prg_whole, in_addr[14:0]};
          end
        end
      end
      sbm_pkg::OP_PPU_READ: begin
        if (in_addr[15:13] == 3'b000) begin
          region_c = sbm_pkg::REGION_CHR;
          if (state.control[sbm_pkg::CTRL_CHR_4K_BIT]) begin
            mapped_c = {1'b0, chr_bank, in_addr[11:0]};
          end else begin
            mapped_c = {1'b0, state.chr_whole_half, in_addr[12:0]};
          end
        end
      end
      default: begin
        region_c = sbm_pkg::REGION_NONE;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp.region         <= region_c;
      rsp.mapped_address <= mapped_c;
      rsp.mirroring      <= control_next[1:0];
    end
  end

  // Checks
  a_shift_count_range: assert property (@(posedge clk) disable iff (rst)
    state.shift_count <= sbm_pkg::SHIFT_LAST)
    else $error("serial shift count out of range");

  a_control_after_reset: assert property (@(posedge clk)
    $past(rst) |-> state.control == sbm_pkg::CTRL_RESET)
    else $error("control word not restored by reset");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_addr) && $stable(in_op))
    else $error("held request lost or changed");

  a_wram_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (rsp.region == sbm_pkg::REGION_WRAM) |-> rsp.mapped_address[17:13] == 5'd0)
    else $error("work RAM offset out of range");

endmodule

`default_nettype wire

>>> hw/rtl/sbm_serial.sv
`default_nettype none

// Serial load register and bank registers of the mapper
module sbm_serial (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic [1:0]         operation,
  input  wire logic [15:13]       addr_top,
  input  wire logic [7:0]         write_data,
  input  wire logic               cfg_write_en,
  input  wire logic [4:0]         cfg_write_data,
  output sbm_pkg::bank_state_t    state,
  output logic [4:0]              control_next
);

  sbm_pkg::bank_state_t state_next;
  logic [4:0] shift_value;
  logic [4:0] shift_value_next;
  logic [3:0] prg_count;
  logic [3:0] prg_count_next;
  logic [4:0] shift_new;
  logic [3:0] last_bank;
  logic       reg_write;

  assign last_bank    = prg_count - 4'd1;
  assign reg_write    = step && (operation == sbm_pkg::OP_CPU_WRITE) && addr_top[15];
  assign shift_new    = {write_data[0], shift_value[4:1]};
  assign control_next = state_next.control;

  // Serial protocol and commit
  always_comb begin
    state_next       = state;
    shift_value_next = shift_value;
    prg_count_next   = prg_count;
    if (reg_write) begin
      if (write_data[7]) begin
        shift_value_next       = '0;
        state_next.shift_count = '0;
        state_next.control     = state.control | sbm_pkg::CTRL_FORCE_16K;
      end else if (state.shift_count == sbm_pkg::SHIFT_LAST) begin
        shift_value_next       = '0;
        state_next.shift_count = '0;
        case (sbm_pkg::target_t'(addr_top[14:13]))
          sbm_pkg::TGT_CONTROL: begin
            state_next.control = shift_new;
          end
          sbm_pkg::TGT_CHR0: begin
            if (state.control[sbm_pkg::CTRL_CHR_4K_BIT]) begin
              state_next.chr_low = shift_new;
            end else begin
              state_next.chr_whole_half = shift_new[4:1];
            end
          end
          sbm_pkg::TGT_CHR1: begin
            // ignored in 8K CHR mode
            if (state.control[sbm_pkg::CTRL_CHR_4K_BIT]) begin
              state_next.chr_high = shift_new;
            end
          end
          default: begin
            case (state.control[3:2])
              sbm_pkg::PRG_MODE_32K_A, sbm_pkg::PRG_MODE_32K_B: begin
                state_next.prg_whole = shift_new[3:1];
              end
              sbm_pkg::PRG_MODE_FIX_FIRST: begin
                state_next.prg_low  = '0;
                state_next.prg_high = shift_new[3:0];
              end
              default: begin
                state_next.prg_low  = shift_new[3:0];
                state_next.prg_high = last_bank;
              end
            endcase
          end
        endcase
      end else begin
        shift_value_next       = shift_new;
        state_next.shift_count = state.shift_count + 3'd1;
      end
    end
    // bank count write loads prg_high with the last bank, in every PRG mode
    if (cfg_write_en) begin
      prg_count_next      = cfg_write_data[3:0];
      state_next.prg_high = cfg_write_data[3:0] - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.control        <= sbm_pkg::CTRL_RESET;
      state.chr_low        <= '0;
      state.chr_high       <= '0;
      state.chr_whole_half <= '0;
      state.prg_low        <= '0;
      state.prg_high       <= sbm_pkg::PRG_COUNT_RESET - 4'd1;
      state.prg_whole      <= '0;
      state.shift_count    <= '0;
      shift_value          <= '0;
      prg_count            <= sbm_pkg::PRG_COUNT_RESET;
    end else begin
      state       <= state_next;
      shift_value <= shift_value_next;
      prg_count   <= prg_count_next;
    end
  end

endmodule

`default_nettype wire
